// ----- hdl/are_pkg.sv -----
`default_nettype none
package are_pkg;

	localparam int STATE_BITS    = 64;
	localparam int PENDING_LIMIT = 256;
	localparam int COUNT_W       = 63;
	localparam logic [COUNT_W-1:0] TOTAL_RESET = 63'd10001025;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BAD_SYM   = 2'd1;
	localparam logic [1:0] ST_BIG_TOTAL = 2'd2;

	// Requests from the sequencer to the byte packer.
	typedef struct packed {
		logic       push;
		logic       bit_val;
		logic       done;
		logic [1:0] status;
	} pk_ctl_t;

	typedef struct packed {
		logic stall;
		logic full;
	} pk_sts_t;

endpackage
`default_nettype wire

// ----- hdl/are_scale.sv -----
`default_nettype none
module are_scale #(
	parameter int STATE_BITS = are_pkg::STATE_BITS
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic                        en,
	input  wire logic                        rbit,
	input  wire logic [are_pkg::COUNT_W-1:0] c,
	input  wire logic [are_pkg::COUNT_W-1:0] d,
	output logic      [STATE_BITS:0]         q
);

	localparam int CW = are_pkg::COUNT_W;

	logic [CW-1:0]     rem_q;
	logic [STATE_BITS:0] q_q;
	logic [CW+1:0]     t;
	logic [CW+1:0]     t1;
	logic [CW+1:0]     t2;
	logic [CW-1:0]     rem_d;
	logic [1:0]        k;

	// One bit of the range per cycle while en is high, MSB first: rem = 2*rem + bit*c, then reduce below d.
	always_comb begin
		t  = {1'b0, rem_q, 1'b0} + (rbit ? {2'b00, c} : '0);
		t1 = t - {2'b00, d};
		t2 = t - {1'b0, d, 1'b0};
		if (t >= {1'b0, d, 1'b0}) begin
			rem_d = t2[CW-1:0];
			k     = 2'd2;
		end else if (t >= {2'b00, d}) begin
			rem_d = t1[CW-1:0];
			k     = 2'd1;
		end else begin
			rem_d = t[CW-1:0];
			k     = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			q_q   <= '0;
		end else if (start) begin
			rem_q <= '0;
			q_q   <= '0;
		end else if (en) begin
			rem_q <= rem_d;
			q_q   <= {q_q[STATE_BITS-1:0], 1'b0} + (STATE_BITS+1)'(k);
		end
	end

	assign q = q_q;

endmodule
`default_nettype wire

// ----- hdl/are_pack.sv -----
`default_nettype none
module are_pack (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire are_pkg::pk_ctl_t ctl,
	output are_pkg::pk_sts_t      sts,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic      [7:0]       m_tdata,   // out_byte
	output logic      [2:0]       m_tuser,   // byte_valid, status[1:0]
	output logic                  m_tlast
);

	logic [7:0] acc_q;
	logic [2:0] cnt_q;
	logic [7:0] hold_q;
	logic       hold_v_q;
	logic       ov_q;
	logic [7:0] obyte_q;
	logic [2:0] ouser_q;
	logic       olast_q;
	logic       out_free;
	logic       full;
	logic       stall;
	logic [7:0] new_byte;

	assign out_free = !ov_q || m_tready;
	assign full     = (cnt_q == 3'd7);
	assign new_byte = {acc_q[6:0], ctl.bit_val};
	assign stall    = (ctl.push && full && hold_v_q && !out_free) || (ctl.done && !out_free);

	assign sts.stall = stall;
	assign sts.full  = full;

	// The newest complete byte waits in the hold register so that the last one can be marked.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			cnt_q    <= '0;
			hold_v_q <= 1'b0;
			ov_q     <= 1'b0;
		end else begin
			if (ov_q && m_tready)
				ov_q <= 1'b0;
			if (ctl.push && !stall) begin
				if (full) begin
					acc_q <= '0;
					cnt_q <= '0;
					if (hold_v_q) begin
						ov_q <= 1'b1;
					end
					hold_v_q <= 1'b1;
				end else begin
					acc_q <= new_byte;
					cnt_q <= cnt_q + 3'd1;
				end
			end
			if (ctl.done && !stall) begin
				ov_q     <= 1'b1;
				hold_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push && !stall && full) begin
			hold_q <= new_byte;
			if (hold_v_q) begin
				obyte_q <= hold_q;
				ouser_q <= {are_pkg::ST_OK, 1'b1};
				olast_q <= 1'b0;
			end
		end
		if (ctl.done && !stall) begin
			olast_q <= 1'b1;
			if (hold_v_q) begin
				obyte_q <= hold_q;
				ouser_q <= {are_pkg::ST_OK, 1'b1};
			end else begin
				obyte_q <= '0;
				ouser_q <= {ctl.status, 1'b0};
			end
		end
	end

	assign m_tvalid = ov_q;
	assign m_tdata  = obyte_q;
	assign m_tuser  = ouser_q;
	assign m_tlast  = olast_q;

endmodule
`default_nettype wire

// ----- hdl/arithmetic_range_encoder.sv -----
`default_nettype none
// Encode checks the word, scales the interval bit-serially, updates it, then emits the
// settled bits (pending bits included) and removes straddles before the result. Finish emits
// a one, pads the byte with zeros and resets the interval and pending count; a rejected word
// goes straight to the result. One word is worked on at a time. A full output register
// stalls the bit loops, and a completed result waits there while the next word is accepted.
// Asynchronous reset clears the interval, pending count and packer and sets total_count to 10001025.
module arithmetic_range_encoder #(
	parameter int STATE_BITS    = are_pkg::STATE_BITS,
	parameter int PENDING_LIMIT = are_pkg::PENDING_LIMIT
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	input  wire logic [127:0]  s_tdata,   // sym_low[62:0], sym_high[125:63], zero fill
	input  wire logic          s_tuser,   // func
	output logic               m_tvalid,
	input  wire logic          m_tready,
	output logic      [7:0]    m_tdata,   // out_byte
	output logic      [2:0]    m_tuser,   // byte_valid, status[1:0]
	output logic               m_tlast,   // last
	input  wire logic          cfg_valid,
	output logic               cfg_ready,
	input  wire logic [62:0]   cfg_data   // total_count
);

	localparam int W  = STATE_BITS;
	localparam int CW = are_pkg::COUNT_W;
	localparam int PW = $clog2(PENDING_LIMIT + 1);
	localparam int NW = $clog2(W + 2);
	localparam logic [CW-1:0] LIMIT = CW'((64'd1 << (W - 2)) + 64'd2);
	localparam logic [PW-1:0] PLIM  = PW'(PENDING_LIMIT);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_CHECK  = 4'd1;
	localparam logic [3:0] S_SCALE  = 4'd2;
	localparam logic [3:0] S_UPDATE = 4'd3;
	localparam logic [3:0] S_SHIFT  = 4'd4;
	localparam logic [3:0] S_PEND   = 4'd5;
	localparam logic [3:0] S_STRAD  = 4'd6;
	localparam logic [3:0] S_FIN    = 4'd7;
	localparam logic [3:0] S_DONE   = 4'd8;

	logic [3:0]    state_q;
	logic [CW-1:0] total_q;
	logic          func_q;
	logic [CW-1:0] slo_q;
	logic [CW-1:0] shi_q;
	logic [W-1:0]  low_q;
	logic [W-1:0]  high_q;
	logic [PW-1:0] pend_q;
	logic [W:0]    r_q;
	logic [NW-1:0] cnt_q;
	logic [1:0]    status_q;
	logic          pbit_q;
	logic          fin_first_q;
	logic          sc_start;
	logic          sc_en;
	logic [W:0]    ql;
	logic [W:0]    qh;
	are_pkg::pk_ctl_t ctl;
	are_pkg::pk_sts_t sts;

	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign sc_start  = (state_q == S_CHECK);
	assign sc_en     = (state_q == S_SCALE);

	are_scale #(.STATE_BITS(W)) u_scale_lo (
		.clk(clk), .arst_n(arst_n), .start(sc_start), .en(sc_en), .rbit(r_q[W]),
		.c(slo_q), .d(total_q), .q(ql)
	);

	are_scale #(.STATE_BITS(W)) u_scale_hi (
		.clk(clk), .arst_n(arst_n), .start(sc_start), .en(sc_en), .rbit(r_q[W]),
		.c(shi_q), .d(total_q), .q(qh)
	);

	always_comb begin
		ctl = '0;
		ctl.status = status_q;
		case (state_q)
			S_SHIFT: begin
				ctl.push    = (low_q[W-1] == high_q[W-1]);
				ctl.bit_val = low_q[W-1];
			end
			S_PEND: begin
				ctl.push    = 1'b1;
				ctl.bit_val = pbit_q;
			end
			S_FIN: begin
				ctl.push    = 1'b1;
				ctl.bit_val = fin_first_q;
			end
			S_DONE: ctl.done = 1'b1;
			default: ctl = '0;
		endcase
	end

	are_pack u_pack (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .sts(sts),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= are_pkg::TOTAL_RESET;
		end else if (cfg_valid) begin
			total_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_q <= s_tuser;
			slo_q  <= s_tdata[62:0];
			shi_q  <= s_tdata[125:63];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			low_q       <= '0;
			high_q      <= '1;
			pend_q      <= '0;
			r_q         <= '0;
			cnt_q       <= '0;
			status_q    <= are_pkg::ST_OK;
			pbit_q      <= 1'b0;
			fin_first_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					status_q <= are_pkg::ST_OK;
					if (func_q) begin
						fin_first_q <= 1'b1;
						state_q     <= S_FIN;
					end else if (slo_q >= shi_q || shi_q > total_q) begin
						status_q <= are_pkg::ST_BAD_SYM;
						state_q  <= S_DONE;
					end else if (total_q > LIMIT) begin
						status_q <= are_pkg::ST_BIG_TOTAL;
						state_q  <= S_DONE;
					end else begin
						r_q     <= {1'b0, high_q - low_q} + (W+1)'(1);
						cnt_q   <= NW'(W + 1);
						state_q <= S_SCALE;
					end
				end
				S_SCALE: begin
					r_q   <= {r_q[W-1:0], 1'b0};
					cnt_q <= cnt_q - NW'(1);
					if (cnt_q == NW'(1)) begin
						state_q <= S_UPDATE;
					end
				end
				S_UPDATE: begin
					low_q   <= low_q + ql[W-1:0];
					high_q  <= low_q + qh[W-1:0] - W'(1);
					state_q <= S_SHIFT;
				end
				S_SHIFT: begin
					if (low_q[W-1] == high_q[W-1]) begin
						if (!sts.stall) begin
							low_q  <= {low_q[W-2:0], 1'b0};
							high_q <= {high_q[W-2:0], 1'b1};
							pbit_q <= ~low_q[W-1];
							if (pend_q != '0) begin
								state_q <= S_PEND;
							end
						end
					end else begin
						state_q <= S_STRAD;
					end
				end
				S_PEND: begin
					if (!sts.stall) begin
						pend_q <= pend_q - PW'(1);
						if (pend_q == PW'(1)) begin
							state_q <= S_SHIFT;
						end
					end
				end
				S_STRAD: begin
					// Interval straddles the middle: drop the second bit and defer it.
					if (low_q[W-2] && !high_q[W-2]) begin
						if (pend_q < PLIM) begin
							pend_q <= pend_q + PW'(1);
						end
						low_q  <= {1'b0, low_q[W-3:0], 1'b0};
						high_q <= {1'b1, high_q[W-3:0], 1'b1};
					end else begin
						state_q <= S_DONE;
					end
				end
				S_FIN: begin
					if (!sts.stall) begin
						fin_first_q <= 1'b0;
						if (sts.full) begin
							low_q   <= '0;
							high_q  <= '1;
							pend_q  <= '0;
							state_q <= S_DONE;
						end
					end
				end
				S_DONE: begin
					if (!sts.stall) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- verif/arithmetic_range_encoder_tb.sv -----
`timescale 1ns / 1ps
`default_nettype none
module arithmetic_range_encoder_tb;

	localparam logic [63:0] TOP_BIT    = 64'h8000_0000_0000_0000;
	localparam logic [63:0] SECOND_BIT = 64'h4000_0000_0000_0000;
	localparam logic [62:0] TOTAL_MAX  = 63'h4000_0000_0000_0002;
	localparam logic FN_ENCODE = 1'b0;
	localparam logic FN_FINISH = 1'b1;

	typedef struct packed {
		logic [7:0] byte_out;
		logic       byte_ok;
		logic       is_last;
		logic [1:0] status;
	} enc_result_t;

	typedef struct {
		logic        fn;
		logic [62:0] lo;
		logic [62:0] hi;
		logic        has_exp;
		logic [1:0]  exp_status;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [127:0] s_tdata;
	logic s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [7:0] m_tdata;
	logic [2:0] m_tuser;
	logic m_tlast;
	logic cfg_valid;
	logic cfg_ready;
	logic [62:0] cfg_data;

	// Predictor state.
	logic [62:0] pr_total;
	logic [63:0] pr_low, pr_high;
	int unsigned pr_pending;
	logic [7:0] pr_acc;
	int unsigned pr_filled;

	enc_result_t expected_words[$];
	int errors;

	arithmetic_range_encoder u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0; #4;
		clk = 1'b1; #4;
	end

	function automatic logic [63:0] scaled_count(logic [62:0] c, logic [63:0] span_m1,
			logic [62:0] d);
		logic [127:0] prod;
		prod = 128'(c) * 128'(span_m1) + 128'(c);
		return 64'(prod / 128'(d));
	endfunction

	task automatic emit_bit(input logic b);
		enc_result_t r;
		pr_acc = {pr_acc[6:0], b};
		pr_filled++;
		if (pr_filled == 8) begin
			r = '{byte_out: pr_acc, byte_ok: 1'b1, is_last: 1'b0, status: are_pkg::ST_OK};
			expected_words.push_back(r);
			pr_acc = '0;
			pr_filled = 0;
		end
	endtask

	task automatic predict_word(input logic fn, input logic [62:0] lo, input logic [62:0] hi);
		int n0;
		logic b;
		logic [63:0] span;
		logic [63:0] nl, nh;
		logic [1:0] st;
		enc_result_t r;
		n0 = expected_words.size();
		st = are_pkg::ST_OK;
		if (fn == FN_FINISH) begin
			emit_bit(1'b1);
			while (pr_filled != 0) emit_bit(1'b0);
			pr_low = '0; pr_high = '1; pr_pending = 0; pr_acc = '0; pr_filled = 0;
		end else if (lo >= hi || hi > pr_total) begin
			st = are_pkg::ST_BAD_SYM;
		end else if (pr_total > TOTAL_MAX) begin
			st = are_pkg::ST_BIG_TOTAL;
		end else begin
			span = pr_high - pr_low;
			nl = pr_low + scaled_count(lo, span, pr_total);
			nh = pr_low + scaled_count(hi, span, pr_total) - 64'd1;
			pr_low = nl; pr_high = nh;
			for (int g = 0; g <= 64 && ((pr_low ^ pr_high) & TOP_BIT) == 0; g++) begin
				b = pr_low[63];
				emit_bit(b);
				for (int k = 0; k < pr_pending; k++) emit_bit(!b);
				pr_pending = 0;
				pr_low = pr_low << 1;
				pr_high = (pr_high << 1) | 64'd1;
			end
			for (int g = 0; g <= 64 && (pr_low & ~pr_high & SECOND_BIT) != 0; g++) begin
				if (pr_pending < are_pkg::PENDING_LIMIT) pr_pending++;
				pr_low = (pr_low << 1) & ~TOP_BIT;
				pr_high = ((pr_high << 1) & ~TOP_BIT) | TOP_BIT | 64'd1;
			end
		end
		if (expected_words.size() == n0) begin
			r = '{byte_out: 8'd0, byte_ok: 1'b0, is_last: 1'b0, status: st};
			expected_words.push_back(r);
		end
		expected_words[$].is_last = 1'b1;
	endtask

	task automatic wait_cycles(input int n);
		repeat (n) @(posedge clk);
	endtask

	// Valid stays high after an accepted word so that a word with no gap follows directly.
	task automatic send_word(input logic fn, input logic [62:0] lo, input logic [62:0] hi);
		int gap;
		gap = $urandom_range(0, 11);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			wait_cycles(gap);
		end
		s_tvalid <= 1'b1;
		s_tuser <= fn;
		s_tdata <= {2'b00, hi, lo};
		predict_word(fn, lo, hi);
		do @(posedge clk); while (!s_tready);
	endtask

	// Waits for the block to drain and settle before a register write.
	task automatic write_total(input logic [62:0] v);
		s_tvalid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		wait_cycles(200);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		pr_total = v;
	endtask

	// Draws a symbol, mostly well formed and inside the current total.
	task automatic send_symbol();
		logic [62:0] a, b;
		int pick;
		pick = $urandom_range(0, 19);
		if (pick == 0) begin
			a = {$urandom, $urandom}; b = {$urandom, $urandom};
		end else if (pick == 1) begin
			a = $urandom_range(0, 5); b = a;
		end else begin
			a = {$urandom, $urandom} % pr_total;
			if ($urandom_range(0, 2) == 0)
				b = a + 1;
			else
				b = a + 1 + ({$urandom, $urandom} % (pr_total - a));
		end
		send_word(FN_ENCODE, a, b);
	endtask

	// Result checker.
	always @(posedge clk) begin
		enc_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_words.size() == 0) begin
				$display("%0t: unexpected word byte=%h user=%b last=%b", $time, m_tdata,
					m_tuser, m_tlast);
				errors++;
			end else begin
				want = expected_words.pop_front();
				if (m_tdata !== want.byte_out || m_tuser !== {want.status, want.byte_ok}
						|| m_tlast !== want.is_last) begin
					$display("%0t: expected byte=%h valid=%b status=%0d last=%b, got byte=%h user=%b last=%b",
						$time, want.byte_out, want.byte_ok, want.status, want.is_last,
						m_tdata, m_tuser, m_tlast);
					errors++;
				end
			end
		end
	end

	// Receiver: waits a random count per word, sometimes not at all.
	initial begin
		int gap;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
			if (gap != 0) begin
				m_tready <= 1'b0;
				wait_cycles(gap);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	initial begin
		#50ms;
		$display("** arithmetic_range_encoder: FAILED **");
		$finish;
	end

	initial begin
		stim_row_t rows[$];
		stim_row_t r;
		logic [62:0] totals[4];
		errors = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0; s_tdata = '0; s_tuser = 1'b0;
		cfg_valid = 1'b0; cfg_data = '0;
		pr_total = are_pkg::TOTAL_RESET;
		pr_low = '0; pr_high = '1; pr_pending = 0; pr_acc = '0; pr_filled = 0;
		wait_cycles(4);
		arst_n <= 1'b1;
		@(posedge clk);

		rows = '{
			'{FN_FINISH, 63'd0, 63'd0, 1'b1, are_pkg::ST_OK},
			'{FN_ENCODE, 63'd5, 63'd5, 1'b1, are_pkg::ST_BAD_SYM},
			'{FN_ENCODE, 63'd7, 63'd3, 1'b1, are_pkg::ST_BAD_SYM},
			'{FN_ENCODE, 63'd0, 63'd10001026, 1'b1, are_pkg::ST_BAD_SYM},
			'{FN_ENCODE, '1, '1, 1'b1, are_pkg::ST_BAD_SYM},
			'{FN_ENCODE, 63'd0, 63'd10001025, 1'b0, are_pkg::ST_OK},
			'{FN_ENCODE, 63'd0, 63'd1, 1'b0, are_pkg::ST_OK},
			'{FN_ENCODE, 63'd10001024, 63'd10001025, 1'b0, are_pkg::ST_OK},
			'{FN_ENCODE, 63'd5000000, 63'd5000001, 1'b0, are_pkg::ST_OK},
			'{FN_ENCODE, 63'd5000512, 63'd5000513, 1'b0, are_pkg::ST_OK},
			'{FN_ENCODE, 63'd4999000, 63'd5002000, 1'b0, are_pkg::ST_OK},
			'{FN_FINISH, '1, '1, 1'b0, are_pkg::ST_OK}
		};
		foreach (rows[i]) begin
			r = rows[i];
			if (r.has_exp && (pr_low != 0 || pr_filled != 0) && r.fn == FN_FINISH) r.has_exp = 0;
			send_word(r.fn, r.lo, r.hi);
			if (r.has_exp && expected_words[$].status !== r.exp_status) begin
				$display("%0t: expected status %0d in predictor, got %0d", $time,
					r.exp_status, expected_words[$].status);
				errors++;
			end
		end
		// Straddling the middle many times to drive the pending count up.
		for (int i = 0; i < 12; i++) send_word(FN_ENCODE, 63'd5000000, 63'd5000100);
		send_word(FN_FINISH, 63'd0, 63'd0);

		// Total above the limit, the smallest and the largest.
		write_total(TOTAL_MAX + 63'd1);
		send_word(FN_ENCODE, 63'd0, 63'd1);
		send_word(FN_ENCODE, 63'd0, 63'd0);
		write_total(63'd0);
		send_word(FN_ENCODE, 63'd0, 63'd1);
		write_total('1);
		send_word(FN_ENCODE, '1 - 63'd1, '1);

		totals = '{63'd1, TOTAL_MAX, 63'd1000, 63'h0000_0fff_ffff_ffff};
		for (int p = 0; p < 4; p++) begin
			write_total(totals[p]);
			for (int i = 0; i < 110; i++) begin
				if ($urandom_range(0, 24) == 0)
					send_word(FN_FINISH, {$urandom, $urandom}, {$urandom, $urandom});
				else
					send_symbol();
			end
		end
		write_total(are_pkg::TOTAL_RESET);
		for (int i = 0; i < 20; i++) send_symbol();
		send_word(FN_FINISH, 63'd0, 63'd0);
		s_tvalid <= 1'b0;

		while (expected_words.size() != 0) @(posedge clk);
		wait_cycles(200);
		if (errors == 0 && expected_words.size() == 0)
			$display("** arithmetic_range_encoder: PASSED **");
		else
			$display("** arithmetic_range_encoder: FAILED **");
		$finish;
	end
endmodule
`default_nettype wire

// ----- files.f -----
hdl/are_pkg.sv
hdl/are_scale.sv
hdl/are_pack.sv
hdl/arithmetic_range_encoder.sv
verif/arithmetic_range_encoder_tb.sv
